@@ sv/vpcm_pkg.sv @@
package vpcm_pkg;

    // Fixed field widths.
    localparam int COORD_BITS = 20;
    localparam int CNT_BITS   = 16;
    localparam int SUM_BITS   = 36;
    localparam int MOM_BITS   = 55;
    localparam int COV_BITS   = 40;
    localparam int MAX_POINTS = 65535;

    // Multiplier and divider widths.
    localparam int T1_BITS   = CNT_BITS + MOM_BITS;   // n * |Sab|
    localparam int T2_BITS   = 2 * SUM_BITS;          // |Sa| * |Sb|
    localparam int HALF_BITS = SUM_BITS / 2;
    localparam int NUM_BITS  = 75;                    // signed numerator
    localparam int DVD_BITS  = NUM_BITS - 1;          // numerator magnitude
    localparam int DIV_BITS  = 2 * CNT_BITS;          // n * (n - 1)
    localparam int STEP_BITS = 7;
    localparam int LAST_TERM = 8;
    localparam int MEAN_TERMS = 3;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL1,
        OP_MUL2L,
        OP_MUL2H,
        OP_NUM,
        OP_LOAD,
        OP_DIV,
        OP_STORE,
        OP_FIN
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WAIT,
        ST_MUL1,
        ST_MUL2L,
        ST_MUL2H,
        ST_NUM,
        ST_LOAD,
        ST_DIV,
        ST_STORE,
        ST_FIN
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] term;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    // First coordinate of each unique covariance pair.
    function automatic logic [1:0] pair_a(input logic [2:0] idx);
        logic [1:0] r;
        begin
            case (idx)
                3'd0, 3'd1, 3'd2: r = 2'd0;
                3'd3, 3'd4:       r = 2'd1;
                default:          r = 2'd2;
            endcase
            return r;
        end
    endfunction

    // Second coordinate of each unique covariance pair.
    function automatic logic [1:0] pair_b(input logic [2:0] idx);
        logic [1:0] r;
        begin
            case (idx)
                3'd0:       r = 2'd0;
                3'd1, 3'd3: r = 2'd1;
                default:    r = 2'd2;
            endcase
            return r;
        end
    endfunction

endpackage

@@ sv/vpcm_ctrl.sv @@
module vpcm_ctrl
    import vpcm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    batch_end,
    input  status_t status,
    output logic    in_stall,
    output cmd_t    cmd
);

    state_t               state_reg, state_next;
    logic [3:0]           term_reg, term_next;
    logic [STEP_BITS-1:0] step_reg, step_next;

    // State, term and divider step registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            term_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            step_reg  <= step_next;
        end
    end

    // Sequence: three means, then six covariance terms, each through the divider.
    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        step_next  = step_reg;
        in_stall   = 1'b1;
        cmd.op     = OP_NONE;
        cmd.term   = term_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && batch_end)
                begin
                    state_next = ST_WAIT;
                    term_next  = '0;
                end
            end
            ST_WAIT:
            begin
                if (!status.out_busy)
                    state_next = ST_LOAD;
            end
            ST_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = ST_MUL2L;
            end
            ST_MUL2L:
            begin
                cmd.op     = OP_MUL2L;
                state_next = ST_MUL2H;
            end
            ST_MUL2H:
            begin
                cmd.op     = OP_MUL2H;
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                cmd.op     = OP_NUM;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.op     = OP_LOAD;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op    = OP_DIV;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(DVD_BITS - 1))
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.op = OP_STORE;
                if (term_reg == 4'(LAST_TERM))
                    state_next = ST_FIN;
                else
                begin
                    term_next = term_reg + 1'b1;
                    if (term_reg < 4'(MEAN_TERMS - 1))
                        state_next = ST_LOAD;
                    else
                        state_next = ST_MUL1;
                end
            end
            ST_FIN:
            begin
                cmd.op     = OP_FIN;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/vpcm_dpath.sv @@
module vpcm_dpath
    import vpcm_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        acc_en,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    input  cmd_t                        cmd,
    input  logic                        out_stall,
    output status_t                     status,
    output logic                        out_valid,
    output logic signed [COORD_BITS-1:0] mean_x,
    output logic signed [COORD_BITS-1:0] mean_y,
    output logic signed [COORD_BITS-1:0] mean_z,
    output logic signed [COV_BITS-1:0]  cov_xx,
    output logic signed [COV_BITS-1:0]  cov_xy,
    output logic signed [COV_BITS-1:0]  cov_xz,
    output logic signed [COV_BITS-1:0]  cov_yy,
    output logic signed [COV_BITS-1:0]  cov_yz,
    output logic signed [COV_BITS-1:0]  cov_zz,
    output logic [CNT_BITS-1:0]         total_points,
    output logic                        overflow
);

    localparam logic [DVD_BITS-1:0] COV_POS_LIM = DVD_BITS'((64'd1 << (COV_BITS - 1)) - 64'd1);
    localparam logic [DVD_BITS-1:0] COV_NEG_LIM = DVD_BITS'(64'd1 << (COV_BITS - 1));

    // Accumulator state.
    logic [CNT_BITS-1:0]        cnt_reg;
    logic signed [SUM_BITS-1:0] sum_reg [3];
    logic signed [MOM_BITS-1:0] mom_reg [6];
    logic                       drop_reg;

    // Working registers for one term.
    logic [T1_BITS-1:0]         t1_reg;
    logic [T2_BITS-1:0]         t2_reg;
    logic                       s1_reg;
    logic                       s2_reg;
    logic signed [NUM_BITS-1:0] num_reg;
    logic [DVD_BITS-1:0]        dvd_reg;
    logic [DIV_BITS:0]          rem_reg;
    logic [DIV_BITS-1:0]        dsr_reg;
    logic                       neg_reg;
    logic                       zero_reg;

    // Result registers.
    logic                       out_valid_reg;
    logic signed [COORD_BITS-1:0] mean_reg [3];
    logic signed [COV_BITS-1:0] cov_reg [6];
    logic [CNT_BITS-1:0]        total_reg;
    logic                       ovf_reg;

    logic signed [COORD_BITS-1:0] pt [3];
    logic [2:0]                 cidx;
    logic signed [SUM_BITS-1:0] sa, sb, sm;
    logic signed [MOM_BITS-1:0] sab;
    logic [SUM_BITS-1:0]        mag_a, mag_b, mag_m;
    logic [MOM_BITS-1:0]        mag_ab;
    logic [2*HALF_BITS+SUM_BITS-HALF_BITS-1:0] part;
    logic signed [NUM_BITS-1:0] t1_s, t2_s;
    logic [DIV_BITS-1:0]        pair_prod;
    logic [DIV_BITS:0]          rem_sh;
    logic                       fits;
    logic [DVD_BITS-1:0]        sat_mag;

    assign pt[0] = pos_x;
    assign pt[1] = pos_y;
    assign pt[2] = pos_z;

    // Operand selection for the current term.
    always_comb
    begin
        cidx   = 3'(cmd.term - 4'(MEAN_TERMS));
        sa     = sum_reg[pair_a(cidx)];
        sb     = sum_reg[pair_b(cidx)];
        sm     = sum_reg[cmd.term[1:0]];
        sab    = mom_reg[cidx];
        mag_a  = sa[SUM_BITS-1] ? SUM_BITS'(-sa) : SUM_BITS'(sa);
        mag_b  = sb[SUM_BITS-1] ? SUM_BITS'(-sb) : SUM_BITS'(sb);
        mag_m  = sm[SUM_BITS-1] ? SUM_BITS'(-sm) : SUM_BITS'(sm);
        mag_ab = sab[MOM_BITS-1] ? MOM_BITS'(-sab) : MOM_BITS'(sab);
        if (cmd.op == OP_MUL2H)
            part = {{HALF_BITS{1'b0}}, mag_a} * {{SUM_BITS{1'b0}}, mag_b[SUM_BITS-1:HALF_BITS]};
        else
            part = {{HALF_BITS{1'b0}}, mag_a} * {{SUM_BITS{1'b0}}, mag_b[HALF_BITS-1:0]};
        t1_s   = signed'({{(NUM_BITS - T1_BITS){1'b0}}, t1_reg});
        t2_s   = signed'({{(NUM_BITS - T2_BITS){1'b0}}, t2_reg});
        pair_prod = {{CNT_BITS{1'b0}}, cnt_reg} * {{CNT_BITS{1'b0}}, cnt_reg - 1'b1};
        rem_sh = {rem_reg[DIV_BITS-1:0], dvd_reg[DVD_BITS-1]};
        fits   = rem_sh >= {1'b0, dsr_reg};
        sat_mag = neg_reg ? ((dvd_reg > COV_NEG_LIM) ? COV_NEG_LIM : dvd_reg)
                          : ((dvd_reg > COV_POS_LIM) ? COV_POS_LIM : dvd_reg);
    end

    // Running count, coordinate sums and second-moment sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                sum_reg[i] <= '0;
            for (int i = 0; i < 6; i++)
                mom_reg[i] <= '0;
        end
        else if (acc_en)
        begin
            if (cnt_reg == CNT_BITS'(MAX_POINTS))
                drop_reg <= 1'b1;
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
                for (int i = 0; i < 3; i++)
                    sum_reg[i] <= sum_reg[i] + SUM_BITS'(pt[i]);
                for (int i = 0; i < 6; i++)
                    mom_reg[i] <= mom_reg[i]
                        + MOM_BITS'(pt[pair_a(3'(i))] * pt[pair_b(3'(i))]);
            end
        end
    end

    // Multiply, numerator and shift-subtract divider steps.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_MUL1:
            begin
                t1_reg <= T1_BITS'({{MOM_BITS{1'b0}}, cnt_reg} * {{CNT_BITS{1'b0}}, mag_ab});
                s1_reg <= sab[MOM_BITS-1];
            end
            OP_MUL2L:
            begin
                t2_reg <= T2_BITS'(part);
                s2_reg <= sa[SUM_BITS-1] ^ sb[SUM_BITS-1];
            end
            OP_MUL2H:
            begin
                t2_reg <= t2_reg + {part[T2_BITS-HALF_BITS-1:0], {HALF_BITS{1'b0}}};
            end
            OP_NUM:
            begin
                num_reg <= (s1_reg ? -t1_s : t1_s) - (s2_reg ? -t2_s : t2_s);
            end
            OP_LOAD:
            begin
                rem_reg <= '0;
                if (cmd.term < 4'(MEAN_TERMS))
                begin
                    dvd_reg  <= DVD_BITS'(mag_m);
                    neg_reg  <= sm[SUM_BITS-1];
                    dsr_reg  <= DIV_BITS'(cnt_reg);
                    zero_reg <= (cnt_reg == '0);
                end
                else
                begin
                    dvd_reg  <= num_reg[NUM_BITS-1] ? DVD_BITS'(-num_reg)
                                                    : DVD_BITS'(num_reg);
                    neg_reg  <= num_reg[NUM_BITS-1];
                    dsr_reg  <= pair_prod;
                    zero_reg <= (cnt_reg <= CNT_BITS'(1));
                end
            end
            OP_DIV:
            begin
                rem_reg <= fits ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
                dvd_reg <= {dvd_reg[DVD_BITS-2:0], fits};
            end
            default:
            begin
            end
        endcase
    end

    // Result registers and the output beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_FIN)
            out_valid_reg <= 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_STORE)
        begin
            if (cmd.term < 4'(MEAN_TERMS))
            begin
                if (zero_reg)
                    mean_reg[cmd.term[1:0]] <= '0;
                else if (neg_reg)
                    mean_reg[cmd.term[1:0]] <= -signed'(dvd_reg[COORD_BITS-1:0]);
                else
                    mean_reg[cmd.term[1:0]] <= signed'(dvd_reg[COORD_BITS-1:0]);
            end
            else
            begin
                if (zero_reg)
                    cov_reg[cidx] <= '0;
                else if (neg_reg)
                    cov_reg[cidx] <= -signed'(sat_mag[COV_BITS-1:0]);
                else
                    cov_reg[cidx] <= signed'(sat_mag[COV_BITS-1:0]);
            end
        end
        if (cmd.op == OP_FIN)
        begin
            total_reg <= cnt_reg;
            ovf_reg   <= drop_reg;
        end
    end

    assign status.out_busy = out_valid_reg;
    assign out_valid    = out_valid_reg;
    assign mean_x       = mean_reg[0];
    assign mean_y       = mean_reg[1];
    assign mean_z       = mean_reg[2];
    assign cov_xx       = cov_reg[0];
    assign cov_xy       = cov_reg[1];
    assign cov_xz       = cov_reg[2];
    assign cov_yy       = cov_reg[3];
    assign cov_yz       = cov_reg[4];
    assign cov_zz       = cov_reg[5];
    assign total_points = total_reg;
    assign overflow     = ovf_reg;

endmodule

@@ sv/voxel_point_covariance_merge_unit.sv @@
// Points without the batch end mark are taken one per cycle while the block is idle.
// A batch end point starts the result computation: a shared 74-step
// shift-subtract divider runs once per mean and per covariance term, and each
// covariance first passes through the MUL1, MUL2L, MUL2H and NUM multiply and subtract states.
// The result stays in its output register until taken; points keep flowing.
// Reset (rst_n low, asynchronous) clears the count, all sums and the drop flag.
module voxel_point_covariance_merge_unit
    import vpcm_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    input  logic                         batch_end,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] mean_x,
    output logic signed [COORD_BITS-1:0] mean_y,
    output logic signed [COORD_BITS-1:0] mean_z,
    output logic signed [COV_BITS-1:0]   cov_xx,
    output logic signed [COV_BITS-1:0]   cov_xy,
    output logic signed [COV_BITS-1:0]   cov_xz,
    output logic signed [COV_BITS-1:0]   cov_yy,
    output logic signed [COV_BITS-1:0]   cov_yz,
    output logic signed [COV_BITS-1:0]   cov_zz,
    output logic [CNT_BITS-1:0]          total_points,
    output logic                         overflow
);

    cmd_t    cmd;
    status_t status;
    logic    acc_en;

    // A point is accumulated on every accepted input beat until the count reaches MAX_POINTS.
    assign acc_en = in_valid && !in_stall;

    vpcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .batch_end (batch_end),
        .status    (status),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    vpcm_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc_en       (acc_en),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .cmd          (cmd),
        .out_stall    (out_stall),
        .status       (status),
        .out_valid    (out_valid),
        .mean_x       (mean_x),
        .mean_y       (mean_y),
        .mean_z       (mean_z),
        .cov_xx       (cov_xx),
        .cov_xy       (cov_xy),
        .cov_xz       (cov_xz),
        .cov_yy       (cov_yy),
        .cov_yz       (cov_yz),
        .cov_zz       (cov_zz),
        .total_points (total_points),
        .overflow     (overflow)
    );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import vpcm_pkg::*;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COV_BITS-1:0]   cov_t;

    // One batch summary as the block should report it.
    typedef struct {
        coord_t              mean [3];
        cov_t                cov [6];
        logic [CNT_BITS-1:0] total;
        logic                ovf;
    } batch_stats_t;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int SETTLE_CYCLES   = 800;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    coord_t              pos_x;
    coord_t              pos_y;
    coord_t              pos_z;
    logic                batch_end;
    logic                out_valid;
    logic                out_stall;
    coord_t              mean_x;
    coord_t              mean_y;
    coord_t              mean_z;
    cov_t                cov_xx;
    cov_t                cov_xy;
    cov_t                cov_xz;
    cov_t                cov_yy;
    cov_t                cov_yz;
    cov_t                cov_zz;
    logic [CNT_BITS-1:0] total_points;
    logic                overflow;

    // Shadow of the block's accumulators.
    int     acc_count;
    longint acc_sum [3];
    longint acc_moment [6];
    logic   acc_dropped;

    batch_stats_t pending_stats [$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int points_sent;
    int batches_checked;
    int idle_cycles;

    voxel_point_covariance_merge_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .batch_end    (batch_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mean_x       (mean_x),
        .mean_y       (mean_y),
        .mean_z       (mean_z),
        .cov_xx       (cov_xx),
        .cov_xy       (cov_xy),
        .cov_xz       (cov_xz),
        .cov_yy       (cov_yy),
        .cov_yz       (cov_yz),
        .cov_zz       (cov_zz),
        .total_points (total_points),
        .overflow     (overflow)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Exact sample covariance term, truncated and saturated to 40 bits.
    function automatic cov_t cov_term(input longint n, input longint sab,
                                      input longint sa, input longint sb);
        logic signed [127:0] wn;
        logic signed [127:0] wab;
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] num;
        logic signed [127:0] q;
        logic signed [127:0] top;
        logic signed [127:0] bottom;
        if (n <= 1)
            return '0;
        wn     = n;
        wab    = sab;
        wa     = sa;
        wb     = sb;
        top    = (128'sd1 <<< (COV_BITS - 1)) - 1;
        bottom = -(128'sd1 <<< (COV_BITS - 1));
        num    = wn * wab - wa * wb;
        q      = num / (wn * (wn - 1));
        if (q > top)
            q = top;
        else if (q < bottom)
            q = bottom;
        return q[COV_BITS-1:0];
    endfunction

    // Accumulate one point and, on a batch end, queue the expected summary.
    function automatic void accumulate_point(input coord_t x, input coord_t y,
                                             input coord_t z, input logic last);
        longint       p [3];
        batch_stats_t s;
        longint       m;
        p[0] = x;
        p[1] = y;
        p[2] = z;
        if (acc_count >= MAX_POINTS)
        begin
            acc_dropped = 1'b1;
        end
        else
        begin
            acc_count++;
            for (int i = 0; i < 3; i++)
                acc_sum[i] += p[i];
            for (int i = 0; i < 6; i++)
                acc_moment[i] += p[pair_a(3'(i))] * p[pair_b(3'(i))];
        end
        if (last)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m = (acc_count == 0) ? 0 : acc_sum[i] / longint'(acc_count);
                s.mean[i] = m[COORD_BITS-1:0];
            end
            for (int i = 0; i < 6; i++)
                s.cov[i] = cov_term(acc_count, acc_moment[i],
                                    acc_sum[pair_a(3'(i))], acc_sum[pair_b(3'(i))]);
            s.total = acc_count[CNT_BITS-1:0];
            s.ovf   = acc_dropped;
            pending_stats = {pending_stats, s};
        end
    endfunction

    // Send one point beat; the valid stays high afterwards until the next call.
    task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                              input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        pos_x     <= x;
        pos_y     <= y;
        pos_z     <= z;
        batch_end <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        points_sent++;
        accumulate_point(x, y, z, last);
    endtask

    // Hold off the sender until every queued summary has been taken.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_stats.size() != 0)
            @(posedge clk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(3))
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(64)) - 32);
            2: return $urandom_range(1) ? coord_t'(20'h7FFFF) : coord_t'(20'h80000);
            default: return coord_t'($signed($urandom_range(8000)) - 4000);
        endcase
    endfunction

    // Corners of the coordinate range, a single-point batch, all signs.
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_point(20'sh80000, 20'sh7FFFF, 20'sh00000, 1'b1);
        send_point(20'sh7FFFF, 20'sh80000, 20'sh00000, 1'b1);
        send_point(20'sh00000, 20'sh00000, 20'sh7FFFF, 1'b0);
        send_point(20'sh80000, 20'sh80000, 20'sh80000, 1'b1);
        send_point(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 1'b0);
        send_point(-20'sd1, 20'sd1, -20'sd1, 1'b1);
        send_point(20'sh55555, 20'shAAAAA, 20'sh0F0F0, 1'b0);
        send_point(20'shAAAAA, 20'sh55555, 20'shF0F0F, 1'b1);
        for (int i = 0; i < 8; i++)
            send_point(20'sh80000, 20'sh80000, 20'sh7FFFF, i == 7);
        send_point(20'sd0, 20'sd0, 20'sd0, 1'b1);
        wait_for_drain();
    endtask

    // Batches of random length and content under one idling mix.
    task automatic test_random_batches(input int n_points, input int idle_pct,
                                       input int stall_pct);
        int left;
        int run;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        left = n_points;
        while (left > 0)
        begin
            run = $urandom_range(1, 16);
            if (run > left)
                run = left;
            for (int i = 0; i < run; i++)
                send_point(rand_coord(), rand_coord(), rand_coord(),
                           (i == run - 1) ? 1'b1 : ($urandom_range(19) == 0));
            left -= run;
        end
    endtask

    // Result checker and receiver stall generation.
    always @(posedge clk)
    begin
        batch_stats_t e;
        coord_t       got_mean [3];
        cov_t         got_cov [6];
        bit           bad;
        if (rst_n && out_valid && !out_stall)
        begin
            got_mean = '{mean_x, mean_y, mean_z};
            got_cov  = '{cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz};
            if (pending_stats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat, count %0d", $realtime,
                             total_points);
            end
            else
            begin
                e   = pending_stats.pop_front();
                bad = 1'b0;
                for (int i = 0; i < 3; i++)
                    if (got_mean[i] !== e.mean[i])
                        bad = 1'b1;
                for (int i = 0; i < 6; i++)
                    if (got_cov[i] !== e.cov[i])
                        bad = 1'b1;
                if (total_points !== e.total || overflow !== e.ovf)
                    bad = 1'b1;
                batches_checked++;
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: mismatch exp mean %0d %0d %0d n %0d ovf %0b",
                                 $realtime, e.mean[0], e.mean[1], e.mean[2],
                                 e.total, e.ovf);
                        $display("    got mean %0d %0d %0d n %0d ovf %0b",
                                 mean_x, mean_y, mean_z, total_points, overflow);
                        $display("    exp cov %0d %0d %0d %0d %0d %0d", e.cov[0],
                                 e.cov[1], e.cov[2], e.cov[3], e.cov[4], e.cov[5]);
                        $display("    got cov %0d %0d %0d %0d %0d %0d", cov_xx,
                                 cov_xy, cov_xz, cov_yy, cov_yz, cov_zz);
                    end
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog on cycles with no beat on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_stall      = 1'b0;
        pos_x          = '0;
        pos_y          = '0;
        pos_z          = '0;
        batch_end      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        points_sent    = 0;
        batches_checked = 0;
        idle_cycles    = 0;
        acc_count      = 0;
        acc_sum        = '{0, 0, 0};
        acc_moment     = '{0, 0, 0, 0, 0, 0};
        acc_dropped    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_batches(230, 0, 0);
        test_random_batches(230, 74, 0);
        wait_for_drain();
        test_random_batches(230, 0, 74);
        test_random_batches(230, 35, 35);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d points through range corners and four idling mixes;",
                 points_sent);
        $display("checked %0d batch summaries, %0d mismatches.", batches_checked,
                 mismatches);
        if (mismatches == 0 && pending_stats.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
